// ===== hw/rtl/glf_pkg.sv =====
// shared types and constants of the g-code line filter
package glf_pkg;

   localparam int DEFAULT_LINE_CAPACITY = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic ACTION_DATA = 1'b0;
   localparam logic ACTION_EOF  = 1'b1;

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_FLUSH,
      OP_EOF
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  char_value;
      logic        flush;
   } queue_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } back_state_type;

endpackage

// ===== hw/rtl/glf_req_if.sv =====
// input byte channel
interface glf_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] byte_value;

   modport source (output valid, output action, output byte_value, input ready);
   modport sink   (input valid, input action, input byte_value, output ready);
endinterface

// ===== hw/rtl/glf_rsp_if.sv =====
// filtered character channel
interface glf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       last_of_line;
   logic       end_of_file;

   modport source (output valid, output char_out, output last_of_line, output end_of_file,
                   input ready);
   modport sink   (input valid, input char_out, input last_of_line, input end_of_file,
                   output ready);
endinterface

// ===== hw/rtl/glf_front.sv =====
// front end: classifies input bytes and tracks line fill and comment skip
module glf_front
   import glf_pkg::*;
#(
   parameter int LINE_CAPACITY = DEFAULT_LINE_CAPACITY,
   localparam int CNT_W = $clog2(LINE_CAPACITY + 1)
) (
   input  logic            clock,
   input  logic            reset,
   glf_req_if.sink         req_chan,
   input  logic            queue_full,
   output logic            push_valid,
   output queue_entry_type push_entry
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             skip_ff, skip_in;
   logic             accept;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;

   always_comb begin
      push_valid = 1'b0;
      push_entry.kind = OP_PUSH;
      push_entry.char_value = req_chan.byte_value;
      push_entry.flush = 1'b0;
      count_in = count_ff;
      skip_in = skip_ff;
      if (accept) begin
         if (req_chan.action == ACTION_EOF) begin
            push_valid = 1'b1;
            push_entry.kind = OP_EOF;
            count_in = '0;
            skip_in = 1'b0;
         end else begin
            priority if (req_chan.byte_value == CHAR_NL) begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else if (count_ff != '0) begin
                  push_valid = 1'b1;
                  push_entry.kind = OP_FLUSH;
                  count_in = '0;
               end
            end else if (skip_ff) begin
               skip_in = 1'b1;
            end else if (req_chan.byte_value == CHAR_CR) begin
               skip_in = 1'b0;
            end else if (req_chan.byte_value == CHAR_SPACE && count_ff == '0) begin
               skip_in = 1'b0;
            end else if (req_chan.byte_value == CHAR_SEMI) begin
               skip_in = 1'b1;
               if (count_ff != '0) begin
                  push_valid = 1'b1;
                  push_entry.kind = OP_FLUSH;
                  count_in = '0;
               end
            end else begin
               push_valid = 1'b1;
               if (count_ff + CNT_W'(1) == CNT_W'(LINE_CAPACITY)) begin
                  push_entry.flush = 1'b1;
                  count_in = '0;
                  skip_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         skip_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         skip_ff <= skip_in;
      end
   end

endmodule

// ===== hw/rtl/glf_queue.sv =====
// small fifo of classified operations between front and back
module glf_queue
   import glf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            pop_valid,
   output queue_entry_type pop_entry
);

   queue_entry_type   entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/glf_back.sv =====
// back end: line store, trailing space trim and character output
module glf_back
   import glf_pkg::*;
#(
   parameter int LINE_CAPACITY = DEFAULT_LINE_CAPACITY,
   localparam int CNT_W = $clog2(LINE_CAPACITY + 1),
   localparam int ADDR_W = $clog2(LINE_CAPACITY)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   input  queue_entry_type pop_entry,
   output logic            pop,
   glf_rsp_if.source       rsp_chan
);

   logic [7:0]        line_mem [LINE_CAPACITY];
   logic [7:0]        rdata_ff;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_eof_ff, rsp_eof_in;

   logic              out_free;
   logic              mem_we;
   logic              load_char;
   logic              load_eof;
   logic              char_is_last;
   logic [CNT_W-1:0]  keep_after_push;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign char_is_last = (CNT_W'(rd_idx_ff) + CNT_W'(1) == len_ff);
   assign keep_after_push = (pop_entry.char_value != CHAR_SPACE) ?
                            fill_ff + CNT_W'(1) : keep_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_entry.kind == OP_FLUSH && keep_ff != '0) begin
                  state_in = ST_READ;
               end else if (pop_entry.kind == OP_PUSH && pop_entry.flush &&
                            keep_after_push != '0) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            if (out_free) begin
               state_in = char_is_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop = 1'b0;
      mem_we = 1'b0;
      load_char = 1'b0;
      load_eof = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_entry.kind)
                  OP_PUSH: begin
                     pop = 1'b1;
                     mem_we = 1'b1;
                  end
                  OP_FLUSH: pop = 1'b1;
                  OP_EOF: begin
                     pop = out_free;
                     load_eof = out_free;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_READ: pop = 1'b0;
         ST_LOAD: load_char = out_free;
         default: pop = 1'b0;
      endcase
   end

   // line bookkeeping and output register
   always_comb begin
      fill_in = fill_ff;
      keep_in = keep_ff;
      len_in = len_ff;
      rd_idx_in = rd_idx_ff;
      if (pop) begin
         unique case (pop_entry.kind)
            OP_PUSH: begin
               if (pop_entry.flush) begin
                  len_in = keep_after_push;
                  fill_in = '0;
                  keep_in = '0;
                  rd_idx_in = '0;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
                  keep_in = keep_after_push;
               end
            end
            OP_FLUSH: begin
               len_in = keep_ff;
               fill_in = '0;
               keep_in = '0;
               rd_idx_in = '0;
            end
            OP_EOF: begin
               fill_in = '0;
               keep_in = '0;
            end
            default: fill_in = '0;
         endcase
      end
      if (load_char && !char_is_last) begin
         rd_idx_in = rd_idx_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_eof_in = rsp_eof_ff;
      if (load_char) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = rdata_ff;
         rsp_last_in = char_is_last;
         rsp_eof_in = 1'b0;
      end else if (load_eof) begin
         rsp_valid_in = 1'b1;
         rsp_char_in = CHAR_NUL;
         rsp_last_in = 1'b1;
         rsp_eof_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[fill_ff[ADDR_W-1:0]] <= pop_entry.char_value;
      end
      rdata_ff <= line_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      rd_idx_ff <= rd_idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eof_ff <= rsp_eof_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         keep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         keep_ff <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.char_out = rsp_char_ff;
   assign rsp_chan.last_of_line = rsp_last_ff;
   assign rsp_chan.end_of_file = rsp_eof_ff;

   a_eof_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eof_ff |-> rsp_last_ff && rsp_char_ff == CHAR_NUL)
      else $error("malformed end marker");
   a_emit_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> len_ff != '0)
      else $error("emitting an empty line");
   a_keep_within_fill: assert property (@(posedge clock) disable iff (reset)
      keep_ff <= fill_ff && fill_ff < CNT_W'(LINE_CAPACITY))
      else $error("line bookkeeping out of range");
   a_no_pop_while_emitting: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !pop)
      else $error("queue popped during line output");

endmodule

// ===== hw/rtl/gcode_line_filter.sv =====
// top level of the g-code line filter
//
// req_chan carries one item per handshake: a data byte (action 0) or an
// end-of-file mark (action 1). rsp_chan returns the filtered command lines
// one character per item, last_of_line set on the final character, and one
// end marker (char 0, last and end_of_file set) for each end-of-file item.
// A front end classifies bytes and keeps the line fill count and the
// comment skip flag; a four-entry queue feeds the back end, which owns the
// line store, trims trailing spaces and streams the line out.
// Input: one byte per cycle while the queue has room; dropped bytes take
// no queue entry, but every byte waits while the queue is full.
// Output: each character passes the registered read of the line store and
// then the load of the output register, and the back end pops no queue
// entry while a line streams out, so the queue buffers the next bytes.
// Reset clears the fill count, skip flag, queue and output valid; the line
// store needs no clearing. When the receiver stalls, the output register
// holds, the back end waits, and the input stalls once the queue is full.
module gcode_line_filter
   import glf_pkg::*;
#(
   parameter int LINE_CAPACITY = DEFAULT_LINE_CAPACITY
) (
   input logic       clock,
   input logic       reset,
   glf_req_if.sink   req_chan,
   glf_rsp_if.source rsp_chan
);

   logic            push_valid;
   queue_entry_type push_entry;
   logic            queue_full;
   logic            pop;
   logic            pop_valid;
   queue_entry_type pop_entry;

   glf_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   glf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   glf_back #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== sim/tb_gcode_line_filter.sv =====
// testbench for gcode_line_filter: directed and random byte streams checked by a predictor
module tb_gcode_line_filter;
   import glf_pkg::*;

   localparam int LINE_CAP = DEFAULT_LINE_CAPACITY;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS = 450;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last_of_line;
      logic       end_of_file;
   } line_char_type;

   logic clock;
   logic reset;

   glf_req_if req_chan ();
   glf_rsp_if rsp_chan ();

   gcode_line_filter #(
      .LINE_CAPACITY(LINE_CAP)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   logic [7:0]    line_buf [LINE_CAP];
   int            fill_cnt;
   logic          skipping;
   line_char_type pending_chars [$];

   int error_count;
   int sent_items;
   int burst_left;

   string cmd_alphabet = "GMTXYZEFS0123456789.-";

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("[gcode_line_filter] ERROR");
      $finish;
   end

   // trim trailing spaces and queue the line
   function automatic void emit_line();
      int n;
      line_char_type c;
      n = fill_cnt;
      while (n > 0 && line_buf[n - 1] == CHAR_SPACE)
         n--;
      fill_cnt = 0;
      for (int k = 0; k < n; k++) begin
         c.char_out = line_buf[k];
         c.last_of_line = (k + 1 == n);
         c.end_of_file = 1'b0;
         pending_chars.push_back(c);
      end
   endfunction

   function automatic void filter_byte(logic act, logic [7:0] val);
      line_char_type c;
      if (act == ACTION_EOF) begin
         fill_cnt = 0;
         skipping = 1'b0;
         c.char_out = CHAR_NUL;
         c.last_of_line = 1'b1;
         c.end_of_file = 1'b1;
         pending_chars.push_back(c);
         return;
      end
      if (val == CHAR_NL) begin
         if (skipping) begin
            skipping = 1'b0;
         end else if (fill_cnt != 0) begin
            emit_line();
         end
         return;
      end
      if (skipping || val == CHAR_CR || (val == CHAR_SPACE && fill_cnt == 0))
         return;
      if (val == CHAR_SEMI) begin
         skipping = 1'b1;
         if (fill_cnt != 0)
            emit_line();
         return;
      end
      line_buf[fill_cnt] = val;
      fill_cnt++;
      if (fill_cnt >= LINE_CAP) begin
         skipping = 1'b1;
         emit_line();
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      line_char_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_chars.size() == 0) begin
            $display("%0t unexpected item: expected none, got char %h last %b eof %b",
                     $time, rsp_chan.char_out, rsp_chan.last_of_line, rsp_chan.end_of_file);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_chan.char_out !== want.char_out ||
                rsp_chan.last_of_line !== want.last_of_line ||
                rsp_chan.end_of_file !== want.end_of_file) begin
               $display("%0t mismatch: expected char %h last %b eof %b,",
                        $time, want.char_out, want.last_of_line, want.end_of_file,
                        " got char %h last %b eof %b",
                        rsp_chan.char_out, rsp_chan.last_of_line, rsp_chan.end_of_file);
               error_count++;
            end
         end
      end
   end

   // receiver stall pattern
   initial begin
      int phase_left;
      int mode;
      phase_left = 0;
      mode = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            mode = $urandom_range(0, 3);
            phase_left = $urandom_range(8, 60);
         end
         phase_left--;
         case (mode)
            0: begin
               rsp_chan.ready <= 1'b1;
            end
            1: begin
               rsp_chan.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_chan.ready <= (phase_left % 7) < 2;
            end
            default: begin
               rsp_chan.ready <= ($urandom_range(0, 5) != 0);
            end
         endcase
      end
   end

   task automatic send_item(input logic act, input logic [7:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= act;
      req_chan.byte_value <= val;
      do
         @(posedge clock);
      while (!req_chan.ready);
      filter_byte(act, val);
      sent_items++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] val);
      send_item(ACTION_DATA, val);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_byte(CHAR_NL);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_plain_lines();
      send_line("G1 X10");
      send_text("  M84  ");
      send_byte(CHAR_CR);
      send_byte(CHAR_NL);
      send_byte(CHAR_NL);
      send_text("T");
      send_byte(CHAR_NL);
      wait_for_drain();
   endtask

   task automatic test_comments();
      send_line(";all comment");
      send_line("G28;home");
      send_line(" ; ;");
      wait_for_drain();
   endtask

   task automatic test_odd_bytes();
      send_byte(8'h09);
      send_byte(CHAR_NUL);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(CHAR_NL);
      wait_for_drain();
   endtask

   task automatic test_end_of_file();
      send_text("G1");
      send_item(ACTION_EOF, 8'hA5);
      send_text("M1;x");
      send_item(ACTION_EOF, 8'h5A);
      send_item(ACTION_EOF, CHAR_NL);
      send_line("G0");
      wait_for_drain();
   endtask

   task automatic test_full_store();
      for (int i = 0; i < LINE_CAP; i++)
         send_byte(8'(8'h41 + (i % 26)));
      send_line("X5 ;c");
      for (int i = 0; i < LINE_CAP - 4; i++)
         send_byte(8'(8'h30 + (i % 10)));
      send_text("    Z");
      send_byte(CHAR_NL);
      for (int i = 0; i < LINE_CAP - 1; i++)
         send_byte(8'(8'h61 + (i % 26)));
      send_byte(CHAR_NL);
      send_line("M84");
      wait_for_drain();
   endtask

   function automatic logic [7:0] random_char();
      if ($urandom_range(0, 9) < 7)
         return cmd_alphabet[$urandom_range(0, cmd_alphabet.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_line();
      int len;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         len = $urandom_range(0, 20);
      else if (pick < 95)
         len = $urandom_range(20, 62);
      else
         len = $urandom_range(60, 70);
      if ($urandom_range(0, 9) < 3)
         repeat ($urandom_range(1, 3)) send_byte(CHAR_SPACE);
      repeat (len) send_byte(random_char());
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 4)) send_byte(CHAR_SPACE);
      if ($urandom_range(0, 4) == 0) begin
         send_byte(CHAR_SEMI);
         repeat ($urandom_range(0, 8))
            send_byte(cmd_alphabet[$urandom_range(0, cmd_alphabet.len() - 1)]);
      end
      if ($urandom_range(0, 9) < 3)
         send_byte(CHAR_CR);
      if ($urandom_range(0, 29) == 0)
         send_item(ACTION_EOF, 8'($urandom_range(0, 255)));
      else
         send_byte(CHAR_NL);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 10)) begin
         if ($urandom_range(0, 9) == 0)
            send_item(ACTION_EOF, 8'($urandom_range(0, 255)));
         else
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_stream();
      int next_drain;
      next_drain = sent_items + 100;
      while (sent_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            send_noise();
         else
            send_random_line();
         if (sent_items >= next_drain) begin
            wait_for_drain();
            next_drain += 100;
         end
      end
      wait_for_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.action = ACTION_DATA;
      req_chan.byte_value = CHAR_NUL;
      fill_cnt = 0;
      skipping = 1'b0;
      error_count = 0;
      sent_items = 0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_plain_lines();
      test_comments();
      test_odd_bytes();
      test_end_of_file();
      test_full_store();
      test_random_stream();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("[gcode_line_filter] OK");
      end else begin
         $display("[gcode_line_filter] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/glf_pkg.sv
hw/rtl/glf_req_if.sv
hw/rtl/glf_rsp_if.sv
hw/rtl/glf_front.sv
hw/rtl/glf_queue.sv
hw/rtl/glf_back.sv
hw/rtl/gcode_line_filter.sv
sim/tb_gcode_line_filter.sv
